/* src/pbk_pkg.sv */
// ----------------------------------------------------------------------------
// pbk_pkg : shared types and constants for the per-block best-k keeper
// Score/key widths, reset score, command codes and the control/status
// structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package pbk_pkg;

  localparam int BLOCKS_DEF    = 4;
  localparam int ENTRIES_DEF   = 8;
  localparam int KEY_BYTES_DEF = 4;

  localparam int SCORE_W  = 16;
  localparam int KEY_IN_W = 32;
  localparam int BLK_W    = 2;
  localparam int RANK_W   = 3;

  // score 100 in unsigned Q8.8
  localparam logic [SCORE_W-1:0] RESET_SCORE = 16'd25600;

  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic clr;     // clearing pass write
    logic latch;   // capture input transaction
    logic rd;      // issue list read
    logic decide;  // offer compare and write
    logic sort;    // one transposition phase
    logic parity;  // phase parity
    logic store;   // write back head of sorted bank
    logic emit;    // load output register
  } cmd_t;

  typedef struct packed {
    logic blk_ok;
    logic is_read;
  } stat_t;

endpackage

/* src/per_block_best_k_keeper.sv */
// ----------------------------------------------------------------------------
// per_block_best_k_keeper : per-block list of lowest-score candidates
//
//   channel | signals                                         | dir
//   in      | in_valid in_ready command block_index           | sink
//           | cand_score cand_key read_rank                   |
//   out     | out_valid out_ready was_replaced entry_score    | source
//           | entry_key                                       |
//
// Offer: one RAM read per entry, then compare/write.
// Read: load, ENTRIES transposition phases, write-back.
// Reset: clearing pass over all BLOCKS*ENTRIES RAM words, in_ready low.
// One transaction at a time; a finished result waits in the output register
// while the next transaction is accepted and worked on.
// ----------------------------------------------------------------------------
module per_block_best_k_keeper #(
  parameter int BLOCKS    = pbk_pkg::BLOCKS_DEF,
  parameter int ENTRIES   = pbk_pkg::ENTRIES_DEF,
  parameter int KEY_BYTES = pbk_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [pbk_pkg::BLK_W-1:0]       block_index,
  input  logic [pbk_pkg::SCORE_W-1:0]     cand_score,
  input  logic [pbk_pkg::KEY_IN_W-1:0]    cand_key,
  input  logic [pbk_pkg::RANK_W-1:0]      read_rank,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            was_replaced,
  output logic [pbk_pkg::SCORE_W-1:0]     entry_score,
  output logic [pbk_pkg::KEY_IN_W-1:0]    entry_key
);

  localparam int CNT_W = $clog2(BLOCKS * ENTRIES + 1);

  pbk_pkg::cmd_t    cmd;
  pbk_pkg::stat_t   stat;
  logic [CNT_W-1:0] idx;

  pbk_ctrl #(
    .BLOCKS  (BLOCKS),
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat)
  );

  pbk_dp #(
    .BLOCKS    (BLOCKS),
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx          (idx),
    .stat         (stat),
    .command      (command),
    .block_index  (block_index),
    .cand_score   (cand_score),
    .cand_key     (cand_key),
    .read_rank    (read_rank),
    .was_replaced (was_replaced),
    .entry_score  (entry_score),
    .entry_key    (entry_key)
  );

endmodule

/* src/pbk_ram.sv */
// ----------------------------------------------------------------------------
// pbk_ram : generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pbk_dp.sv */
// ----------------------------------------------------------------------------
// pbk_dp : datapath of the best-k keeper
// Candidate RAM, input capture, maximum tracker, sort bank with
// odd-even transposition lanes, result and output registers.
// ----------------------------------------------------------------------------
module pbk_dp #(
  parameter int BLOCKS    = pbk_pkg::BLOCKS_DEF,
  parameter int ENTRIES   = pbk_pkg::ENTRIES_DEF,
  parameter int KEY_BYTES = pbk_pkg::KEY_BYTES_DEF,
  localparam int CNT_W = $clog2(BLOCKS * ENTRIES + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pbk_pkg::cmd_t                     cmd,
  input  logic [CNT_W-1:0]                  idx,
  output pbk_pkg::stat_t                    stat,
  input  logic                              command,
  input  logic [pbk_pkg::BLK_W-1:0]         block_index,
  input  logic [pbk_pkg::SCORE_W-1:0]       cand_score,
  input  logic [pbk_pkg::KEY_IN_W-1:0]      cand_key,
  input  logic [pbk_pkg::RANK_W-1:0]        read_rank,
  output logic                              was_replaced,
  output logic [pbk_pkg::SCORE_W-1:0]       entry_score,
  output logic [pbk_pkg::KEY_IN_W-1:0]      entry_key
);

  localparam int DEPTH = BLOCKS * ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW    = 8 * ((KEY_BYTES > 4) ? 4 : KEY_BYTES);
  localparam int SW    = pbk_pkg::SCORE_W;
  localparam int RW    = SW + KW;

  logic                        cmd_q;
  logic [pbk_pkg::BLK_W-1:0]   blk_q;
  logic [SW-1:0]               sc_q;
  logic [KW-1:0]               key_q;
  logic [pbk_pkg::RANK_W-1:0]  rank_q;

  logic                        rv_q;
  logic [IW-1:0]               rv_idx;
  logic [SW-1:0]               best;
  logic [IW-1:0]               pick;

  logic [SW-1:0]               sbank      [ENTRIES];
  logic [KW-1:0]               kbank      [ENTRIES];
  logic [SW-1:0]               sbank_next [ENTRIES];
  logic [KW-1:0]               kbank_next [ENTRIES];

  logic                        res_rep;
  logic [SW-1:0]               res_score;
  logic [KW-1:0]               res_key;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [RW-1:0]               wdata;
  logic [AW-1:0]               raddr;
  logic [RW-1:0]               rdata;
  logic [AW-1:0]               base;
  logic [SW-1:0]               rd_score;
  logic [KW-1:0]               rd_key;

  assign base     = AW'(AW'(blk_q) * AW'(ENTRIES));
  assign raddr    = base + AW'(idx[IW-1:0]);
  assign rd_score = rdata[RW-1:KW];
  assign rd_key   = rdata[KW-1:0];

  assign stat.blk_ok  = (32'(blk_q) < 32'(BLOCKS));
  assign stat.is_read = (cmd_q == pbk_pkg::CMD_READ);

  pbk_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = base + AW'(pick);
    wdata = {sc_q, key_q};
    priority if (cmd.clr) begin
      we    = 1'b1;
      waddr = idx[AW-1:0];
      wdata = {pbk_pkg::RESET_SCORE, KW'(0)};
    end else if (cmd.decide) begin
      we = (best > sc_q);
    end else if (cmd.store) begin
      we    = 1'b1;
      waddr = base + AW'(idx[IW-1:0]);
      wdata = {sbank[0], kbank[0]};
    end else begin
      we = 1'b0;
    end
  end

  // bank: shift-in on read data, transposition phase, or rotate on write-back
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      sbank_next[i] = sbank[i];
      kbank_next[i] = kbank[i];
    end
    priority if (rv_q || cmd.store) begin
      for (int i = 0; i < ENTRIES; i++) begin
        sbank_next[i] = sbank[(i + 1) % ENTRIES];
        kbank_next[i] = kbank[(i + 1) % ENTRIES];
      end
      if (rv_q) begin
        sbank_next[ENTRIES-1] = rd_score;
        kbank_next[ENTRIES-1] = rd_key;
      end
    end else if (cmd.sort) begin
      for (int i = 0; i + 1 < ENTRIES; i++) begin
        if (((i % 2) == int'(cmd.parity)) && (sbank[i] > sbank[i+1])) begin
          sbank_next[i]   = sbank[i+1];
          kbank_next[i]   = kbank[i+1];
          sbank_next[i+1] = sbank[i];
          kbank_next[i+1] = kbank[i];
        end
      end
    end else begin
      sbank_next[0] = sbank[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    rv_idx <= idx[IW-1:0];
    for (int i = 0; i < ENTRIES; i++) begin
      sbank[i] <= sbank_next[i];
      kbank[i] <= kbank_next[i];
    end
    if (rv_q && (rd_score > best)) begin
      best <= rd_score;
      pick <= rv_idx;
    end
    if (cmd.decide) begin
      res_rep <= (best > sc_q);
    end
    if (cmd.store && (32'(idx) == 32'(rank_q))) begin
      res_score <= sbank[0];
      res_key   <= kbank[0];
    end
    if (cmd.latch) begin
      cmd_q     <= command;
      blk_q     <= block_index;
      sc_q      <= cand_score;
      key_q     <= cand_key[KW-1:0];
      rank_q    <= read_rank;
      best      <= '0;
      pick      <= '0;
      res_rep   <= 1'b0;
      res_score <= '0;
      res_key   <= '0;
    end
    if (cmd.emit) begin
      was_replaced <= res_rep;
      entry_score  <= res_score;
      entry_key    <= pbk_pkg::KEY_IN_W'(res_key);
    end
  end

endmodule

/* src/pbk_ctrl.sv */
// ----------------------------------------------------------------------------
// pbk_ctrl : controller of the best-k keeper
// Sequences the clearing pass, offer scan, load/sort/write-back of a
// list, and the output handshake.
// ----------------------------------------------------------------------------
module pbk_ctrl #(
  parameter int BLOCKS  = pbk_pkg::BLOCKS_DEF,
  parameter int ENTRIES = pbk_pkg::ENTRIES_DEF,
  localparam int CNT_W = $clog2(BLOCKS * ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pbk_pkg::cmd_t    cmd,
  output logic [CNT_W-1:0] idx,
  input  pbk_pkg::stat_t   stat
);

  localparam int DEPTH = BLOCKS * ENTRIES;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_LOAD     = 4'd5;
  localparam logic [3:0] S_SORT     = 4'd6;
  localparam logic [3:0] S_STORE    = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  localparam logic [CNT_W-1:0] N_ENT  = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] N_LAST = CNT_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] D_LAST = CNT_W'(DEPTH - 1);

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign in_ready = (state == S_IDLE);
  assign idx      = cnt;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (cnt == D_LAST) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_next = '0;
        priority if (!stat.blk_ok) begin
          state_next = S_DONE;
        end else if (stat.is_read) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN, S_LOAD: begin
        cmd.rd = (cnt < N_ENT);
        if (cnt == N_ENT) begin
          state_next = (state == S_SCAN) ? S_DECIDE : S_SORT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_DONE;
      end
      S_SORT: begin
        cmd.sort   = 1'b1;
        cmd.parity = cnt[0];
        if (cnt == N_LAST) begin
          state_next = S_STORE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (cnt == N_LAST) begin
          state_next = S_DONE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrote pending output");

  a_decide_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> ($past(state) == S_SCAN))
    else $error("offer decided without scan");

  a_bank_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT || state == S_STORE) |-> (cnt < N_ENT))
    else $error("bank index out of range");

endmodule
